/* hw/rtl/lsr_pkg.sv */
`timescale 1ns / 1ps
// lsr_pkg: shared constants, types and helpers for the lru stack replacement block
// used by lsr_ctrl, lsr_datapath and lru_stack_replacement_top; no dependencies

package lsr_pkg;

	localparam int NUM_SETS = 1024;
	localparam int ASSOC    = 16;

	localparam int SET_W  = 10;
	localparam int WAY_W  = 4;
	localparam int POS_W  = 4;
	localparam int WORD_W = POS_W * ASSOC;
	localparam int IDX_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int CMP_W  = 18;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(ASSOC - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} lsr_state_t;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} lsr_op_t;

	typedef struct packed {
		logic clear_wr;
		logic load;
		logic upd_wr;
		logic out_load;
	} lsr_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_update;
		logic upd_ok;
	} lsr_sts_t;

	// stack word after reset: way w at position w
	function automatic logic [WORD_W-1:0] reset_word();
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < ASSOC; i++) begin
			w[i*POS_W +: POS_W] = POS_W'(i);
		end
		return w;
	endfunction

endpackage

/* hw/rtl/lru_stack_replacement_top.sv */
`timescale 1ns / 1ps
// lru_stack_replacement_top: top level of the true lru stack replacement block
// depends on lsr_pkg, lsr_ctrl and lsr_datapath

// Keeps a true LRU stack for each of NUM_SETS sets in a single-port-write RAM of set words.
// After reset the block runs a clearing pass over all NUM_SETS sets (1024 by default) with
// in_stall held high, putting way w at position w in every set. Each transaction then does
// a registered RAM read of the set word, followed by a write-back of the moved stack or a
// load of the victim into the output register. in_stall stays high until it is done, so a
// new transaction is taken only after the last one finishes. A victim transaction may wait
// for its load while a previous result is still stalled at the output; an update produces no result.

module lru_stack_replacement_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [lsr_pkg::SET_W-1:0] set_number,
	input  logic [lsr_pkg::WAY_W-1:0] touched_way,
	input  logic [lsr_pkg::POS_W-1:0] insert_position,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lsr_pkg::WAY_W-1:0] victim_way
);

	lsr_pkg::lsr_cmd_t cmd;
	lsr_pkg::lsr_sts_t sts;

	lsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsr_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.set_number      (set_number),
		.touched_way     (touched_way),
		.insert_position (insert_position),
		.victim_way      (victim_way)
	);

endmodule

/* hw/rtl/lsr_ctrl.sv */
`timescale 1ns / 1ps
// lsr_ctrl: sequencer for the clearing pass, the set read and the modify or result step
// depends on lsr_pkg

module lsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  lsr_pkg::lsr_sts_t sts,
	output lsr_pkg::lsr_cmd_t cmd
);

	lsr_pkg::lsr_state_t state_q;
	lsr_pkg::lsr_state_t state_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lsr_pkg::ST_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = lsr_pkg::ST_IDLE;
				end
			end
			lsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = lsr_pkg::ST_EXEC;
				end
			end
			lsr_pkg::ST_EXEC: begin
				if (sts.is_update || out_free) begin
					state_nxt = lsr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lsr_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lsr_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			lsr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			lsr_pkg::ST_EXEC: begin
				cmd.upd_wr   = sts.is_update && sts.upd_ok;
				cmd.out_load = !sts.is_update && out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsr_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == lsr_pkg::ST_EXEC))
		else $error("accepted transaction did not move to exec");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && out_valid_q && out_stall))
		else $error("result loaded over a stalled result");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> (in_stall && !cmd.upd_wr && !cmd.load))
		else $error("transaction activity during clearing pass");

endmodule

/* hw/rtl/lsr_datapath.sv */
`timescale 1ns / 1ps
// lsr_datapath: set word ram, item registers, victim search and stack move logic
// depends on lsr_pkg; driven by lsr_ctrl commands

module lsr_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsr_pkg::lsr_cmd_t           cmd,
	output lsr_pkg::lsr_sts_t           sts,
	input  logic                        operation,
	input  logic [lsr_pkg::SET_W-1:0]   set_number,
	input  logic [lsr_pkg::WAY_W-1:0]   touched_way,
	input  logic [lsr_pkg::POS_W-1:0]   insert_position,
	output logic [lsr_pkg::WAY_W-1:0]   victim_way
);

	logic [lsr_pkg::WORD_W-1:0] mem [lsr_pkg::NUM_SETS];

	logic [lsr_pkg::IDX_W-1:0]  clr_cnt_q;
	logic                       op_q;
	logic                       set_ok_q;
	logic                       way_ok_q;
	logic [lsr_pkg::WAY_W-1:0]  way_q;
	logic [lsr_pkg::POS_W-1:0]  pos_q;
	logic [lsr_pkg::IDX_W-1:0]  idx_q;
	logic [lsr_pkg::WORD_W-1:0] word_q;
	logic [lsr_pkg::WAY_W-1:0]  victim_q;

	logic [lsr_pkg::CMP_W-1:0]  set_wide;
	logic [lsr_pkg::IDX_W-1:0]  idx_in;
	logic                       set_ok_in;
	logic                       way_ok_in;
	logic [lsr_pkg::POS_W-1:0]  pos_in;
	logic [lsr_pkg::WAY_W-1:0]  victim_nxt;
	logic [lsr_pkg::WORD_W-1:0] moved_word;
	logic [lsr_pkg::IDX_W-1:0]  wr_addr;
	logic [lsr_pkg::WORD_W-1:0] wr_data;
	logic                       wr_en;

	assign set_wide  = lsr_pkg::CMP_W'(set_number);
	assign idx_in    = set_wide[lsr_pkg::IDX_W-1:0];
	assign set_ok_in = set_wide < lsr_pkg::CMP_W'(lsr_pkg::NUM_SETS);
	assign way_ok_in = lsr_pkg::CMP_W'(touched_way) < lsr_pkg::CMP_W'(lsr_pkg::ASSOC);
	assign pos_in    = (insert_position > lsr_pkg::POS_LAST) ? lsr_pkg::POS_LAST
	                                                         : insert_position;

	// lowest way sitting at the bottom of the stack, way 0 if none or if the set is out of range
	always_comb begin
		victim_nxt = '0;
		for (int w = lsr_pkg::ASSOC - 1; w >= 0; w--) begin
			if (word_q[w*lsr_pkg::POS_W +: lsr_pkg::POS_W] == lsr_pkg::POS_LAST) begin
				victim_nxt = lsr_pkg::WAY_W'(w);
			end
		end
		if (!set_ok_q) begin
			victim_nxt = '0;
		end
	end

	// each way adjusts its own position independently, wrapping in four bits
	always_comb begin
		logic [lsr_pkg::POS_W-1:0] old_pos;
		logic [lsr_pkg::POS_W-1:0] p;
		moved_word = word_q;
		old_pos    = word_q[way_q*lsr_pkg::POS_W +: lsr_pkg::POS_W];
		for (int w = 0; w < lsr_pkg::ASSOC; w++) begin
			p = word_q[w*lsr_pkg::POS_W +: lsr_pkg::POS_W];
			if (p < old_pos) begin
				p = p + 1'b1;
			end
			if (p <= pos_q) begin
				p = p - 1'b1;
			end
			if (lsr_pkg::WAY_W'(w) == way_q) begin
				p = pos_q;
			end
			moved_word[w*lsr_pkg::POS_W +: lsr_pkg::POS_W] = p;
		end
	end

	assign wr_en   = cmd.clear_wr || cmd.upd_wr;
	assign wr_addr = cmd.clear_wr ? clr_cnt_q : idx_q;
	assign wr_data = cmd.clear_wr ? lsr_pkg::reset_word() : moved_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q   <= mem[idx_in];
			op_q     <= operation;
			set_ok_q <= set_ok_in;
			way_ok_q <= way_ok_in;
			way_q    <= touched_way;
			pos_q    <= pos_in;
			idx_q    <= idx_in;
		end
		if (cmd.out_load) begin
			victim_q <= victim_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = clr_cnt_q == lsr_pkg::IDX_W'(lsr_pkg::NUM_SETS - 1);
	assign sts.is_update  = op_q == lsr_pkg::OP_UPDATE;
	assign sts.upd_ok     = set_ok_q && way_ok_q;
	assign victim_way     = victim_q;

	a_upd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_wr |-> (set_ok_q && way_ok_q && op_q == lsr_pkg::OP_UPDATE))
		else $error("stack write for an out of range transaction");

	a_bad_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !set_ok_q) |=> (victim_way == '0))
		else $error("victim for an out of range set is not way 0");

	a_pos_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (pos_q <= lsr_pkg::POS_LAST))
		else $error("insertion position beyond the bottom of the stack");

endmodule
